[rtl/core/cpa_pkg.sv]
// Shared types and codes for the capture pixel adjust pipeline.
`default_nettype none

package cpa_pkg;

    localparam int unsigned CH_W  = 8;
    localparam int unsigned NCH   = 3;
    localparam int unsigned PCT_W = 7;

    localparam logic [1:0] CFG_BG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_BG_PERCENT = 2'd1;
    localparam logic [1:0] CFG_COLOR_MODE = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd3;

    localparam logic [1:0] MODE_COLOR = 2'd0;
    localparam logic [1:0] MODE_GRAY  = 2'd1;
    localparam logic [1:0] MODE_BW    = 2'd2;

    localparam logic [CH_W-1:0] CH_MAX    = 8'hFF;
    localparam logic [CH_W-1:0] THR_RESET = 8'd128;

    typedef struct packed {
        logic             bg_en;
        logic [PCT_W-1:0] pct;
        logic [1:0]       mode;
        logic [CH_W-1:0]  thr;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic kind;
    } t_ctl;

    typedef struct packed {
        logic [CH_W-1:0]           tv;
        logic [CH_W-1:0]           ti;
        logic [NCH-1:0][CH_W-1:0]  bg;
        logic [NCH-1:0][CH_W-1:0]  pix;
    } t_item;

    typedef struct packed {
        logic valid;
        logic gray;
        logic bw;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/cpa_reduce.sv]
// Background reduction stages: multiply, divide by 100, add and saturate, or pass the pixel through when off.
`default_nettype none

module cpa_reduce (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire cpa_pkg::t_cfg                            i_cfg,
    input  wire cpa_pkg::t_ctl                            i_ctl,
    input  wire cpa_pkg::t_item                           i_item,
    output cpa_pkg::t_ctl                                 o_ctl,
    output logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0]    o_addr,
    output logic [cpa_pkg::CH_W-1:0]                      o_ti,
    output logic [cpa_pkg::CH_W-1:0]                      o_tv
);

    localparam int unsigned PROD_W = cpa_pkg::CH_W + cpa_pkg::PCT_W;
    localparam int unsigned MUL_W  = 2 * PROD_W;
    localparam int unsigned SHIFT  = 21;
    localparam int unsigned Q_W    = MUL_W - SHIFT;
    localparam int unsigned SUM_W  = cpa_pkg::CH_W + 2;
    localparam logic [PROD_W-1:0] RECIP = PROD_W'((2 ** SHIFT + 99) / 100);

    cpa_pkg::t_ctl r_ctl1, r_ctl2, r_ctl3;

    logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] r_pix1, r_pix2, r_adr3;
    logic [cpa_pkg::NCH-1:0][PROD_W-1:0]        r_prod1;
    logic [cpa_pkg::NCH-1:0][Q_W-1:0]           r_q2;
    logic [cpa_pkg::CH_W-1:0]                   r_ti1, r_ti2, r_ti3;
    logic [cpa_pkg::CH_W-1:0]                   r_tv1, r_tv2, r_tv3;

    logic [cpa_pkg::NCH-1:0][MUL_W-1:0]         w_mul;
    logic [cpa_pkg::NCH-1:0][SUM_W-1:0]         w_sum;
    logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] w_adr;
    logic                                       w_red_on;

    assign w_red_on = i_cfg.bg_en && (i_cfg.pct != '0);

    always_comb begin
        for (int c = 0; c < cpa_pkg::NCH; c++) begin
            w_mul[c] = MUL_W'(r_prod1[c]) * MUL_W'(RECIP);
            w_sum[c] = SUM_W'(r_pix2[c]) + SUM_W'(r_q2[c]);
            if (!w_red_on) begin
                w_adr[c] = r_pix2[c];
            end else if (w_sum[c] > SUM_W'(cpa_pkg::CH_MAX)) begin
                w_adr[c] = cpa_pkg::CH_MAX;
            end else begin
                w_adr[c] = w_sum[c][cpa_pkg::CH_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < cpa_pkg::NCH; c++) begin
                r_pix1[c]  <= i_item.pix[c];
                r_prod1[c] <= PROD_W'(cpa_pkg::CH_MAX - i_item.bg[c]) * PROD_W'(i_cfg.pct);
                r_pix2[c]  <= r_pix1[c];
                r_q2[c]    <= w_mul[c][MUL_W-1:SHIFT];
                r_adr3[c]  <= w_adr[c];
            end
            r_ti1 <= i_item.ti;
            r_tv1 <= i_item.tv;
            r_ti2 <= r_ti1;
            r_tv2 <= r_tv1;
            r_ti3 <= r_ti2;
            r_tv3 <= r_tv2;
        end
    end

    assign o_ctl  = r_ctl3;
    assign o_addr = r_adr3;
    assign o_ti   = r_ti3;
    assign o_tv   = r_tv3;

endmodule

`default_nettype wire

[rtl/core/cpa_tone.sv]
// Tone table stage: one table copy per channel, written together, read per channel.
`default_nettype none

module cpa_tone (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire cpa_pkg::t_ctl                            i_ctl,
    input  wire logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] i_addr,
    input  wire logic [cpa_pkg::CH_W-1:0]                 i_ti,
    input  wire logic [cpa_pkg::CH_W-1:0]                 i_tv,
    output logic                                          o_valid,
    output logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0]    o_data
);

    localparam int unsigned DEPTH = 2 ** cpa_pkg::CH_W;

    logic [cpa_pkg::CH_W-1:0] r_tbl_r [DEPTH];
    logic [cpa_pkg::CH_W-1:0] r_tbl_g [DEPTH];
    logic [cpa_pkg::CH_W-1:0] r_tbl_b [DEPTH];
    logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] r_q;
    logic r_valid;
    logic w_wr;

    assign w_wr = i_en && i_ctl.valid && i_ctl.kind;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_tbl_r[i_ti] <= i_tv;
            r_tbl_g[i_ti] <= i_tv;
            r_tbl_b[i_ti] <= i_tv;
        end
        if (i_en) begin
            r_q[0] <= r_tbl_r[i_addr[0]];
            r_q[1] <= r_tbl_g[i_addr[1]];
            r_q[2] <= r_tbl_b[i_addr[2]];
        end
    end

    // drop table write items here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid && !i_ctl.kind;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_q;

endmodule

`default_nettype wire

[rtl/core/cpa_mode.sv]
// Color mode stages: gray sum, then mode select and threshold into the output register.
`default_nettype none

module cpa_mode (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire cpa_pkg::t_cfg                            i_cfg,
    input  wire logic                                     i_valid,
    input  wire logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] i_data,
    output cpa_pkg::t_sts                                 o_sts,
    output logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0]    o_data
);

    localparam int unsigned GS_W = cpa_pkg::CH_W + 5;
    localparam logic [GS_W-1:0] K_R = GS_W'(11);
    localparam logic [GS_W-1:0] K_G = GS_W'(16);
    localparam logic [GS_W-1:0] K_B = GS_W'(5);

    logic                                       r_v5;
    logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] r_rgb5, r_out;
    logic [cpa_pkg::CH_W-1:0]                   r_gray5;
    cpa_pkg::t_sts                              r_sts;

    logic [GS_W-1:0]                            w_gsum;
    logic [cpa_pkg::CH_W-1:0]                   w_bw;
    logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] w_out;
    logic                                       w_gray;
    logic                                       w_is_bw;

    assign w_gsum = GS_W'(i_data[0]) * K_R + GS_W'(i_data[1]) * K_G + GS_W'(i_data[2]) * K_B;
    assign w_bw   = (r_gray5 >= i_cfg.thr) ? cpa_pkg::CH_MAX : '0;

    always_comb begin
        w_gray  = 1'b1;
        w_is_bw = 1'b0;
        w_out   = {cpa_pkg::NCH{r_gray5}};
        case (i_cfg.mode)
            cpa_pkg::MODE_COLOR: begin
                w_gray = 1'b0;
                w_out  = r_rgb5;
            end
            cpa_pkg::MODE_BW: begin
                if (i_cfg.thr != '0) begin
                    w_is_bw = 1'b1;
                    w_out   = {cpa_pkg::NCH{w_bw}};
                end
            end
            default: begin
                w_out = {cpa_pkg::NCH{r_gray5}};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5  <= 1'b0;
            r_sts <= '0;
        end else if (i_en) begin
            r_v5        <= i_valid;
            r_sts.valid <= r_v5;
            r_sts.gray  <= w_gray;
            r_sts.bw    <= w_is_bw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb5  <= i_data;
            r_gray5 <= w_gsum[GS_W-1:5];
            r_out   <= w_out;
        end
    end

    assign o_sts  = r_sts;
    assign o_data = r_out;

endmodule

`default_nettype wire

[rtl/core/capture_pixel_adjust.sv]
// Top level: stream ports, configuration registers and the six-stage pixel pipeline.
//
// Camera pixel adjustment: background lift toward white, a 256-entry tone table and a
// color, grayscale or black-and-white output stage. One item is taken in every clock;
// a pixel item yields its result after the reduce, tone and mode stages, a table write item
// takes one pipeline slot and yields nothing. The rate is set by the tone table: it is
// held as three copies, one per channel, so each copy has a single read port and all
// three channels are looked up in the same cycle. When the output is not taken the whole
// pipeline holds, and input ready falls in that cycle. Table entries hold unknown values
// after reset until written; there is no clearing pass. Configuration writes are always
// taken and should be made while no item is in flight.
`default_nettype none

module capture_pixel_adjust (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pix_red, pix_green, pix_blue, bg_red, bg_green, bg_blue, table_index, table_value
    input  wire logic [63:0] s_tdata,
    // kind
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_red, out_green, out_blue
    output logic [23:0]      m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    cpa_pkg::t_cfg  r_cfg;
    cpa_pkg::t_ctl  w_ctl_in, w_ctl3;
    cpa_pkg::t_item w_item;
    cpa_pkg::t_sts  w_sts;

    logic [cpa_pkg::NCH-1:0][cpa_pkg::CH_W-1:0] w_addr, w_map, w_out;
    logic [cpa_pkg::CH_W-1:0] w_ti, w_tv;
    logic w_map_v;
    logic w_en;

    assign w_en        = !w_sts.valid || m_tready;
    assign s_tready    = w_en;
    assign o_cfg_ready = 1'b1;

    assign w_ctl_in.valid = s_tvalid;
    assign w_ctl_in.kind  = s_tuser;
    assign w_item         = s_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bg_en <= 1'b0;
            r_cfg.pct   <= '0;
            r_cfg.mode  <= cpa_pkg::MODE_COLOR;
            r_cfg.thr   <= cpa_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cpa_pkg::CFG_BG_ENABLE:  r_cfg.bg_en <= i_cfg_data[0];
                cpa_pkg::CFG_BG_PERCENT: r_cfg.pct   <= i_cfg_data[cpa_pkg::PCT_W-1:0];
                cpa_pkg::CFG_COLOR_MODE: r_cfg.mode  <= i_cfg_data[1:0];
                cpa_pkg::CFG_THRESHOLD:  r_cfg.thr   <= i_cfg_data;
                default:                 r_cfg.thr   <= r_cfg.thr;
            endcase
        end
    end

    cpa_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_ctl   (w_ctl_in),
        .i_item  (w_item),
        .o_ctl   (w_ctl3),
        .o_addr  (w_addr),
        .o_ti    (w_ti),
        .o_tv    (w_tv)
    );

    cpa_tone u_tone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl3),
        .i_addr  (w_addr),
        .i_ti    (w_ti),
        .i_tv    (w_tv),
        .o_valid (w_map_v),
        .o_data  (w_map)
    );

    cpa_mode u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_valid (w_map_v),
        .i_data  (w_map),
        .o_sts   (w_sts),
        .o_data  (w_out)
    );

    assign m_tvalid = w_sts.valid;
    assign m_tdata  = w_out;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output valid right after reset");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_gray_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_sts.gray |->
            m_tdata[15:8] == m_tdata[7:0] && m_tdata[23:16] == m_tdata[7:0])
        else $error("gray output channels differ");

    a_bw_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && w_sts.bw |-> m_tdata[7:0] == 8'h00 || m_tdata[7:0] == 8'hFF)
        else $error("binary output not black or white");

endmodule

`default_nettype wire
